FILE: rtl/psagg_pkg.sv
// Shared sizes, codes and the token format that travels along the sorted-cell chain
// of the pixel stack aggregator. No dependencies.
package psagg_pkg;

    localparam int MAX_MAPS = 256;
    localparam int CNT_W    = $clog2(MAX_MAPS + 1);
    localparam int SAMPLE_W = 32;
    localparam int VALUE_W  = 40;
    localparam int STEP_W   = $clog2(VALUE_W);

    // Aggregation methods
    localparam logic [2:0] METH_AVG    = 3'd0;
    localparam logic [2:0] METH_MIN    = 3'd1;
    localparam logic [2:0] METH_MAX    = 3'd2;
    localparam logic [2:0] METH_MEDIAN = 3'd3;
    localparam logic [2:0] METH_SUM    = 3'd4;
    localparam logic [2:0] METH_COUNT  = 3'd5;

    // Sample store types
    localparam logic [1:0] STORE_BYTE  = 2'd0;
    localparam logic [1:0] STORE_SHORT = 2'd1;
    localparam logic [1:0] STORE_LONG  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_METHOD      = 2'd0;
    localparam logic [1:0] REG_STORE_TYPE  = 2'd1;
    localparam logic [1:0] REG_UNDEF_LONG  = 2'd2;
    localparam logic [1:0] REG_UNDEF_SHORT = 2'd3;

    // Kinds of token handed from cell to cell
    typedef enum logic [2:0] {
        TOK_NONE,
        TOK_DATA,    // insert a sample, dropping duplicates
        TOK_CLEAR,   // empty every cell it passes
        TOK_COUNT,   // add up occupied cells
        TOK_SELECT   // pick the entry at a given rank, emptying cells
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t                   kind;
        logic signed [SAMPLE_W-1:0]  data;
        logic [CNT_W-1:0]            cnt;
    } token_t;

endpackage

FILE: rtl/psagg_cell.sv
// One cell of the sorted distinct-value chain: holds one entry and passes a
// token to its right neighbor every cycle. Depends on psagg_pkg.
module psagg_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  psagg_pkg::token_t tok_in,
    output psagg_pkg::token_t tok_out
);

    logic                                 used_reg;
    logic                                 used_next;
    logic signed [psagg_pkg::SAMPLE_W-1:0] val_reg;
    logic signed [psagg_pkg::SAMPLE_W-1:0] val_next;
    psagg_pkg::token_t                    tok_reg;
    psagg_pkg::token_t                    tok_next;

    always_comb begin
        used_next     = used_reg;
        val_next      = val_reg;
        tok_next      = tok_in;
        case (tok_in.kind)
            psagg_pkg::TOK_DATA: begin
                if (!used_reg) begin
                    // empty cell: settle here
                    used_next     = 1'b1;
                    val_next      = tok_in.data;
                    tok_next.kind = psagg_pkg::TOK_NONE;
                end else if (tok_in.data == val_reg) begin
                    tok_next.kind = psagg_pkg::TOK_NONE;
                end else if ($signed(tok_in.data) < $signed(val_reg)) begin
                    // keep the smaller value, push the held one onward
                    val_next      = tok_in.data;
                    tok_next.data = val_reg;
                end
            end
            psagg_pkg::TOK_CLEAR: begin
                used_next = 1'b0;
            end
            psagg_pkg::TOK_COUNT: begin
                tok_next.cnt = tok_in.cnt + psagg_pkg::CNT_W'(used_reg);
            end
            psagg_pkg::TOK_SELECT: begin
                used_next    = 1'b0;
                tok_next.cnt = tok_in.cnt - psagg_pkg::CNT_W'(1);
                if (tok_in.cnt == '0) begin
                    tok_next.data = val_reg;
                end
            end
            default: begin
                tok_next.kind = psagg_pkg::TOK_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= 1'b0;
            tok_reg.kind <= psagg_pkg::TOK_NONE;
        end else begin
            used_reg <= used_next;
            val_reg  <= val_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/psagg_div.sv
// Restoring divider, one quotient bit per cycle, for the stack average.
// Unsigned magnitude by a nonzero sample count. Depends on psagg_pkg.
module psagg_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [psagg_pkg::VALUE_W-1:0] dividend,
    input  logic [psagg_pkg::CNT_W-1:0]   divisor,
    output logic                          done,
    output logic [psagg_pkg::VALUE_W-1:0] quotient
);

    logic [psagg_pkg::VALUE_W-1:0] quo_reg;
    logic [psagg_pkg::VALUE_W-1:0] quo_next;
    logic [psagg_pkg::CNT_W-1:0]   rem_reg;
    logic [psagg_pkg::CNT_W-1:0]   rem_next;
    logic [psagg_pkg::CNT_W-1:0]   dvs_reg;
    logic [psagg_pkg::STEP_W-1:0]  step_reg;
    logic                          run_reg;
    logic                          done_reg;
    logic [psagg_pkg::CNT_W:0]     trial;
    logic [psagg_pkg::CNT_W:0]     trial_sub;
    logic                          fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[psagg_pkg::VALUE_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        rem_next  = fits ? trial_sub[psagg_pkg::CNT_W-1:0] : trial[psagg_pkg::CNT_W-1:0];
        quo_next  = {quo_reg[psagg_pkg::VALUE_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                step_reg <= '0;
                run_reg  <= 1'b1;
            end else if (run_reg) begin
                quo_reg  <= quo_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg + psagg_pkg::STEP_W'(1);
                if (step_reg == psagg_pkg::STEP_W'(psagg_pkg::VALUE_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/pixel_stack_aggregate_top.sv
// Pixel stack aggregator top level: input/result channels, configuration,
// accumulators and the sorted-cell chain. Depends on psagg_pkg, psagg_cell,
// psagg_div.
//
// Usage: feed the samples of one pixel on s_sample, one transfer per cycle,
// with s_last on the final map. Samples equal to either no-data sentinel are
// skipped. One result leaves on m_value / m_undefined per stack.
// Throughput: one sample per cycle while a stack streams in. After the last
// sample s_ready drops while the result is formed:
//   minimum, maximum, sum, count: the block passes ST_CLOSE and ST_OUT, and
//   the result is then registered;
//   average: set by the bit-serial divider in ST_DIV (skipped for an empty stack);
//   median: set by a count token and then a select token, each walking the
//   full chain of MAX_MAPS cells.
// The result sits in an output register, so a new stack can stream in while
// the receiver stalls; the block only waits on m_ready when the next result
// is ready and the previous one has not been taken.
// Reset (synchronous, active low) clears the accumulators, empties the cell
// chain and restores the register defaults: average, byte store, long
// sentinel -2147483647, short sentinel -32767.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wr_data; the
// user must write it only while the block is idle; the block does not check.
module pixel_stack_aggregate_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [1:0]                           cfg_index,
    input  logic [31:0]                          cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [psagg_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                 s_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [psagg_pkg::VALUE_W-1:0] m_value,
    output logic                                 m_undefined
);

    localparam int SW = psagg_pkg::SAMPLE_W;
    localparam int VW = psagg_pkg::VALUE_W;
    localparam int CW = psagg_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_CLOSE,
        ST_CNT,
        ST_SEL,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [2:0]            method_reg;
    logic [1:0]            store_type_reg;
    logic signed [SW-1:0]  undef_long_reg;
    logic signed [SW-1:0]  undef_short_reg;
    logic [CW-1:0]         valid_count_reg, valid_count_next;
    logic signed [VW-1:0]  sum_reg, sum_next;
    logic signed [SW-1:0]  min_reg, min_next;
    logic signed [SW-1:0]  max_reg, max_next;
    logic [CW-1:0]         distinct_reg, distinct_next;
    logic signed [SW-1:0]  med_reg, med_next;
    logic                  m_valid_reg, m_valid_next;
    logic signed [VW-1:0]  m_value_reg, m_value_next;
    logic                  m_undefined_reg, m_undefined_next;

    psagg_pkg::token_t     chain [psagg_pkg::MAX_MAPS+1];
    psagg_pkg::token_t     inj;
    psagg_pkg::token_t     chain_exit;

    logic                  s_xfer;
    logic                  sample_ok;
    logic                  out_free;
    logic                  div_start;
    logic                  div_done;
    logic [VW-1:0]         div_quotient;
    logic [VW-1:0]         sum_mag;
    logic signed [VW-1:0]  avg_val;
    logic signed [VW-1:0]  res_value;
    logic                  res_undef;
    logic                  clampable;

    assign s_ready    = (state_reg == ST_ACC);
    assign s_xfer     = s_valid && s_ready;
    assign sample_ok  = (s_sample != undef_long_reg) && (s_sample != undef_short_reg)
                        && (valid_count_reg < CW'(psagg_pkg::MAX_MAPS));
    assign out_free   = !m_valid_reg || m_ready;
    assign chain_exit = chain[psagg_pkg::MAX_MAPS];
    assign chain[0]   = inj;

    // Sorted distinct store as a row of cells
    for (genvar gi = 0; gi < psagg_pkg::MAX_MAPS; gi++) begin : g_cell
        psagg_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (chain[gi]),
            .tok_out (chain[gi+1])
        );
    end

    assign sum_mag = sum_reg[VW-1] ? VW'(-sum_reg) : VW'(sum_reg);

    psagg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (valid_count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign avg_val = sum_reg[VW-1] ? -$signed(div_quotient) : $signed(div_quotient);

    // Result selection and clamping
    always_comb begin
        res_value = '0;
        res_undef = 1'b0;
        clampable = 1'b0;
        case (method_reg)
            psagg_pkg::METH_AVG: begin
                res_undef = (valid_count_reg == '0);
                res_value = avg_val;
                clampable = 1'b1;
            end
            psagg_pkg::METH_MIN: begin
                res_undef = (valid_count_reg == '0);
                res_value = VW'(min_reg);
                clampable = 1'b1;
            end
            psagg_pkg::METH_MAX: begin
                res_undef = (valid_count_reg == '0);
                res_value = VW'(max_reg);
                clampable = 1'b1;
            end
            psagg_pkg::METH_MEDIAN: begin
                res_undef = (distinct_reg == '0);
                res_value = VW'(med_reg);
                clampable = 1'b1;
            end
            psagg_pkg::METH_SUM: begin
                res_value = sum_reg;
            end
            psagg_pkg::METH_COUNT: begin
                res_value = VW'($unsigned(valid_count_reg));
            end
            default: begin
                res_undef = 1'b1;
            end
        endcase
        if (res_undef) begin
            res_value = '0;
        end else if (clampable) begin
            if (store_type_reg == psagg_pkg::STORE_BYTE && !res_value[VW-1]
                && (|res_value[VW-2:8])) begin
                res_value = VW'(255);
            end else if (store_type_reg == psagg_pkg::STORE_LONG && !res_value[VW-1]
                         && (|res_value[VW-2:SW-1])) begin
                res_value = VW'(undef_long_reg);
            end
        end
    end

    always_comb begin
        state_next       = state_reg;
        valid_count_next = valid_count_reg;
        sum_next         = sum_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        distinct_next    = distinct_reg;
        med_next         = med_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_value_next     = m_value_reg;
        m_undefined_next = m_undefined_reg;
        div_start        = 1'b0;
        inj.kind         = psagg_pkg::TOK_NONE;
        inj.data         = s_sample;
        inj.cnt          = '0;
        case (state_reg)
            ST_ACC: begin
                if (s_xfer) begin
                    if (sample_ok) begin
                        inj.kind         = psagg_pkg::TOK_DATA;
                        valid_count_next = valid_count_reg + CW'(1);
                        sum_next         = sum_reg + VW'(s_sample);
                        if (s_sample < min_reg) min_next = s_sample;
                        if (s_sample > max_reg) max_next = s_sample;
                    end
                    if (s_last) state_next = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                // trail the stack's last sample with a closing token
                if (method_reg == psagg_pkg::METH_MEDIAN) begin
                    inj.kind   = psagg_pkg::TOK_COUNT;
                    state_next = ST_CNT;
                end else begin
                    inj.kind = psagg_pkg::TOK_CLEAR;
                    if (method_reg == psagg_pkg::METH_AVG && valid_count_reg != '0) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_CNT: begin
                if (chain_exit.kind == psagg_pkg::TOK_COUNT) begin
                    distinct_next = chain_exit.cnt;
                    inj.kind      = psagg_pkg::TOK_SELECT;
                    inj.cnt       = chain_exit.cnt >> 1;
                    state_next    = ST_SEL;
                end
            end
            ST_SEL: begin
                if (chain_exit.kind == psagg_pkg::TOK_SELECT) begin
                    med_next   = chain_exit.data;
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_value_next     = res_value;
                    m_undefined_next = res_undef;
                    // reset the accumulators for the next pixel
                    valid_count_next = '0;
                    sum_next         = '0;
                    min_next         = {1'b0, {(SW-1){1'b1}}};
                    max_next         = {1'b1, {(SW-1){1'b0}}};
                    distinct_next    = '0;
                    state_next       = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_ACC;
            method_reg      <= psagg_pkg::METH_AVG;
            store_type_reg  <= psagg_pkg::STORE_BYTE;
            undef_long_reg  <= -SW'(2147483647);
            undef_short_reg <= -SW'(32767);
            valid_count_reg <= '0;
            sum_reg         <= '0;
            min_reg         <= {1'b0, {(SW-1){1'b1}}};
            max_reg         <= {1'b1, {(SW-1){1'b0}}};
            distinct_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            valid_count_reg <= valid_count_next;
            sum_reg         <= sum_next;
            min_reg         <= min_next;
            max_reg         <= max_next;
            distinct_reg    <= distinct_next;
            med_reg         <= med_next;
            m_valid_reg     <= m_valid_next;
            m_value_reg     <= m_value_next;
            m_undefined_reg <= m_undefined_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    psagg_pkg::REG_METHOD:      method_reg      <= cfg_wr_data[2:0];
                    psagg_pkg::REG_STORE_TYPE:  store_type_reg  <= cfg_wr_data[1:0];
                    psagg_pkg::REG_UNDEF_LONG:  undef_long_reg  <= cfg_wr_data;
                    psagg_pkg::REG_UNDEF_SHORT: undef_short_reg <= cfg_wr_data;
                    default:                    method_reg      <= method_reg;
                endcase
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value     = m_value_reg;
    assign m_undefined = m_undefined_reg;

endmodule

FILE: rtl/psagg_chk.sv
// Port-level checks for pixel_stack_aggregate_top, attached by bind.
// Depends on psagg_pkg for field widths.
module psagg_chk (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 s_last,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [psagg_pkg::VALUE_W-1:0] m_value,
    input logic                                 m_undefined
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_undefined))
        else $error("result changed while stalled");

    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_undefined |-> m_value == '0)
        else $error("undefined result with nonzero value");

    a_close_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("input taken right after the last sample of a stack");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind pixel_stack_aggregate_top psagg_chk u_psagg_chk (.*);

FILE: tb/sv/pixel_stack_aggregate_top_tb.sv
// Self-checking testbench for pixel_stack_aggregate_top: directed stimulus table, then
// random pixel stacks under random config, checked against an in-bench reduction model.
// Depends on psagg_pkg and the pixel_stack_aggregate_top RTL.
module pixel_stack_aggregate_top_tb;

    localparam bit [2:0] METHOD_UNUSED6 = 3'd6;
    localparam bit [2:0] METHOD_UNUSED7 = 3'd7;

    localparam bit [1:0] STORE_UNUSED = 2'd3;

    localparam logic [31:0] NODATA_LONG_DFLT  = -32'sd2147483647;
    localparam logic [31:0] NODATA_SHORT_DFLT = -32'sd32767;
    localparam logic [31:0] INT_MAX_BITS      = 32'h7fff_ffff;
    localparam logic [31:0] INT_MIN_BITS      = 32'h8000_0000;

    localparam int SETTLE_CYCLES = 2 * psagg_pkg::MAX_MAPS + 100;
    localparam int HOLD_CYCLES   = 3000;
    localparam int RANDOM_ITEMS  = 1000;

    typedef struct packed {
        logic signed [psagg_pkg::VALUE_W-1:0] value;
        logic                                 undefined;
    } pixel_result_t;

    typedef struct packed {
        bit            is_cfg;
        bit [2:0]      method;
        bit [1:0]      store;
        logic [31:0]   nd_long;
        logic [31:0]   nd_short;
        logic [31:0]   sample;
        bit            last;
        bit            checked;
        pixel_result_t want;
    } stim_row_t;

    logic                                  aclk;
    logic                                  aresetn;
    logic                                  cfg_wr_en;
    logic [1:0]                            cfg_index;
    logic [31:0]                           cfg_wr_data;
    logic                                  s_valid;
    logic                                  s_ready;
    logic signed [psagg_pkg::SAMPLE_W-1:0] s_sample;
    logic                                  s_last;
    logic                                  m_valid;
    logic                                  m_ready;
    logic signed [psagg_pkg::VALUE_W-1:0]  m_value;
    logic                                  m_undefined;

    // configuration and per-pixel accumulators of the reduction model
    bit [2:0]    agg_method;
    bit [1:0]    store_kind;
    int          nodata_long;
    int          nodata_short;
    int unsigned stack_valid;
    longint      stack_sum;
    longint      stack_min;
    longint      stack_max;
    int          distinct_vals[$];

    pixel_result_t pending_pixels[$];
    stim_row_t     stim_table[$];
    int            mismatch_count = 0;
    bit            steady = 1'b0;
    bit            hold_request = 1'b0;
    bit            hold_done = 1'b0;

    pixel_stack_aggregate_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_undefined (m_undefined)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void clear_pixel();
        stack_valid = 0;
        stack_sum   = 0;
        stack_min   = 64'sd2147483647;
        stack_max   = -64'sd2147483648;
        distinct_vals.delete();
    endfunction

    // Fold one sample into the running stack; on the last sample produce the pixel result.
    function automatic void reduce_stack_sample(input logic [31:0] smp, input logic lst,
                                                output bit closes, output pixel_result_t res);
        longint s;
        longint v;
        int     pos;
        bit     undef;
        bit     clampable;
        s = longint'(signed'(smp));
        v = 0;
        undef = 1'b0;
        clampable = 1'b0;
        closes = lst;
        res = '0;
        if (s != longint'(nodata_long) && s != longint'(nodata_short)
                && stack_valid < psagg_pkg::MAX_MAPS) begin
            stack_valid++;
            stack_sum += s;
            if (s < stack_min) stack_min = s;
            if (s > stack_max) stack_max = s;
            pos = 0;
            while (pos < distinct_vals.size() && distinct_vals[pos] < int'(s))
                pos++;
            if (!(pos < distinct_vals.size() && distinct_vals[pos] == int'(s))
                    && distinct_vals.size() < psagg_pkg::MAX_MAPS)
                distinct_vals.insert(pos, int'(s));
        end
        if (!lst) return;
        case (agg_method)
            psagg_pkg::METH_AVG: begin
                if (stack_valid > 0) v = stack_sum / longint'(stack_valid);
                else undef = 1'b1;
                clampable = 1'b1;
            end
            psagg_pkg::METH_MIN: begin
                if (stack_valid > 0) v = stack_min;
                else undef = 1'b1;
                clampable = 1'b1;
            end
            psagg_pkg::METH_MAX: begin
                if (stack_valid > 0) v = stack_max;
                else undef = 1'b1;
                clampable = 1'b1;
            end
            psagg_pkg::METH_MEDIAN: begin
                if (distinct_vals.size() > 0) v = distinct_vals[distinct_vals.size() / 2];
                else undef = 1'b1;
                clampable = 1'b1;
            end
            psagg_pkg::METH_SUM:   v = stack_sum;
            psagg_pkg::METH_COUNT: v = longint'(stack_valid);
            default:               undef = 1'b1;
        endcase
        if (undef) begin
            v = 0;
        end else if (clampable) begin
            if (store_kind == psagg_pkg::STORE_BYTE && v > 255)
                v = 255;
            else if (store_kind == psagg_pkg::STORE_LONG && v >= 64'sd2147483648)
                v = longint'(nodata_long);
        end
        res.value     = v[psagg_pkg::VALUE_W-1:0];
        res.undefined = undef;
        clear_pixel();
    endfunction

    // Offer one sample; return at the falling edge after its transfer, valid still high.
    task automatic send_sample(input logic [31:0] smp, input logic lst,
                               input bit checked, input pixel_result_t want);
        pixel_result_t got;
        bit            closes;
        if (!steady && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        s_last   <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        reduce_stack_sample(smp, lst, closes, got);
        if (closes) pending_pixels.push_back(checked ? want : got);
        @(negedge aclk);
    endtask

    // Drain, let the cell chain settle, then write all four registers.
    task automatic program_regs(input bit [2:0] m, input bit [1:0] st,
                                input logic [31:0] nd_l, input logic [31:0] nd_s);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= psagg_pkg::REG_METHOD;
        cfg_wr_data <= 32'(m);
        @(negedge aclk);
        cfg_index   <= psagg_pkg::REG_STORE_TYPE;
        cfg_wr_data <= 32'(st);
        @(negedge aclk);
        cfg_index   <= psagg_pkg::REG_UNDEF_LONG;
        cfg_wr_data <= nd_l;
        @(negedge aclk);
        cfg_index   <= psagg_pkg::REG_UNDEF_SHORT;
        cfg_wr_data <= nd_s;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        agg_method   = m;
        store_kind   = st;
        nodata_long  = nd_l;
        nodata_short = nd_s;
    endtask

    function automatic stim_row_t cfg_row(input bit [2:0] m, input bit [1:0] st,
                                          input logic [31:0] nd_l, input logic [31:0] nd_s);
        stim_row_t r;
        r = '0;
        r.is_cfg   = 1'b1;
        r.method   = m;
        r.store    = st;
        r.nd_long  = nd_l;
        r.nd_short = nd_s;
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic [31:0] smp, input bit lst);
        stim_row_t r;
        r = '0;
        r.sample = smp;
        r.last   = lst;
        return r;
    endfunction

    function automatic stim_row_t checked_row(input logic [31:0] smp, input bit lst,
                                              input longint v, input bit u);
        stim_row_t r;
        r = item_row(smp, lst);
        r.checked        = 1'b1;
        r.want.value     = v[psagg_pkg::VALUE_W-1:0];
        r.want.undefined = u;
        return r;
    endfunction

    function automatic logic [31:0] pick_nodata();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'(int'($urandom_range(600)) - 300);
            2:       return $urandom_range(1) ? INT_MAX_BITS : INT_MIN_BITS;
            default: return NODATA_LONG_DFLT;
        endcase
    endfunction

    always @(posedge aclk) begin : watch_results
        pixel_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                flag_mismatch($sformatf("result %0d/%0d with nothing expected",
                                        m_value, m_undefined));
            end else begin
                want = pending_pixels.pop_front();
                if (m_value !== want.value)
                    flag_mismatch($sformatf("value %0d, expected %0d", m_value, want.value));
                if (m_undefined !== want.undefined)
                    flag_mismatch($sformatf("undefined %b, expected %b",
                                            m_undefined, want.undefined));
            end
        end
    end

    // Result side: random backpressure, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 12);
            end
        end
    end

    initial begin : stimulus
        int          phase;
        int          sent;
        int          n_stacks;
        int          len;
        bit [2:0]    m;
        bit [1:0]    st;
        logic [31:0] nd_l;
        logic [31:0] nd_s;
        logic [31:0] smp;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = psagg_pkg::REG_METHOD;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_sample    = '0;
        s_last      = 1'b0;
        agg_method   = psagg_pkg::METH_AVG;
        store_kind   = psagg_pkg::STORE_BYTE;
        nodata_long  = NODATA_LONG_DFLT;
        nodata_short = NODATA_SHORT_DFLT;
        clear_pixel();

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset defaults: average, byte store
        stim_table.push_back(checked_row(NODATA_SHORT_DFLT, 1'b1, 0, 1'b1));
        stim_table.push_back(item_row(32'd1000, 1'b0));
        stim_table.push_back(checked_row(32'd2000, 1'b1, 255, 1'b0));
        stim_table.push_back(item_row(-32'sd7, 1'b0));
        stim_table.push_back(item_row(-32'sd2, 1'b1));
        stim_table.push_back(cfg_row(psagg_pkg::METH_MIN, psagg_pkg::STORE_BYTE,
                                     NODATA_LONG_DFLT, NODATA_SHORT_DFLT));
        stim_table.push_back(item_row(INT_MAX_BITS, 1'b0));
        stim_table.push_back(checked_row(INT_MIN_BITS, 1'b1, -64'sd2147483648, 1'b0));
        stim_table.push_back(cfg_row(psagg_pkg::METH_MAX, psagg_pkg::STORE_LONG,
                                     NODATA_LONG_DFLT, NODATA_SHORT_DFLT));
        stim_table.push_back(item_row(NODATA_LONG_DFLT, 1'b0));
        stim_table.push_back(checked_row(INT_MAX_BITS, 1'b1, 64'sd2147483647, 1'b0));
        stim_table.push_back(cfg_row(psagg_pkg::METH_MEDIAN, psagg_pkg::STORE_SHORT,
                                     NODATA_LONG_DFLT, NODATA_SHORT_DFLT));
        stim_table.push_back(item_row(32'd5, 1'b0));
        stim_table.push_back(item_row(32'd5, 1'b0));
        stim_table.push_back(item_row(32'd3, 1'b0));
        stim_table.push_back(item_row(32'd9, 1'b1));
        // sum is never clamped, and an empty sum is a defined zero
        stim_table.push_back(cfg_row(psagg_pkg::METH_SUM, psagg_pkg::STORE_BYTE,
                                     NODATA_LONG_DFLT, NODATA_SHORT_DFLT));
        stim_table.push_back(item_row(INT_MAX_BITS, 1'b0));
        stim_table.push_back(item_row(INT_MAX_BITS, 1'b0));
        stim_table.push_back(checked_row(NODATA_SHORT_DFLT, 1'b1, 64'sd4294967294, 1'b0));
        stim_table.push_back(checked_row(NODATA_SHORT_DFLT, 1'b1, 0, 1'b0));
        stim_table.push_back(cfg_row(psagg_pkg::METH_COUNT, psagg_pkg::STORE_LONG,
                                     32'd0, 32'd100));
        stim_table.push_back(item_row(32'd100, 1'b0));
        stim_table.push_back(item_row(32'd0, 1'b0));
        stim_table.push_back(checked_row(32'd7, 1'b1, 1, 1'b0));
        stim_table.push_back(cfg_row(METHOD_UNUSED6, STORE_UNUSED, NODATA_LONG_DFLT,
                                     NODATA_SHORT_DFLT));
        stim_table.push_back(checked_row(32'd1, 1'b1, 0, 1'b1));
        stim_table.push_back(cfg_row(METHOD_UNUSED7, psagg_pkg::STORE_SHORT,
                                     NODATA_LONG_DFLT, NODATA_SHORT_DFLT));
        stim_table.push_back(checked_row(32'd3, 1'b1, 0, 1'b1));
        stim_table.push_back(cfg_row(psagg_pkg::METH_MAX, STORE_UNUSED, NODATA_LONG_DFLT,
                                     NODATA_SHORT_DFLT));
        stim_table.push_back(checked_row(32'd300, 1'b1, 300, 1'b0));

        foreach (stim_table[i]) begin
            if (stim_table[i].is_cfg)
                program_regs(stim_table[i].method, stim_table[i].store,
                             stim_table[i].nd_long, stim_table[i].nd_short);
            else
                send_sample(stim_table[i].sample, stim_table[i].last,
                            stim_table[i].checked, stim_table[i].want);
        end

        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            // walk every method and store type with extreme sentinels first
            if (phase < 8) begin
                m    = 3'(phase);
                st   = 2'(phase % 4);
                nd_l = phase[0] ? INT_MAX_BITS : INT_MIN_BITS;
                nd_s = phase[0] ? INT_MIN_BITS : INT_MAX_BITS;
            end else begin
                m    = ($urandom_range(99) < 10) ? 3'($urandom_range(7, 6))
                                                 : 3'($urandom_range(5));
                st   = 2'($urandom_range(3));
                nd_l = pick_nodata();
                nd_s = pick_nodata();
            end
            steady = (phase == 2);
            program_regs(m, st, nd_l, nd_s);
            n_stacks = $urandom_range(40, 15);
            for (int k = 0; k < n_stacks; k++) begin
                if (phase == 4 && k == 3) hold_request = 1'b1;
                // one overlong stack runs past the per-pixel sample limit
                len = (phase == 5 && k == 0) ? 300 : $urandom_range(8, 1);
                for (int j = 0; j < len; j++) begin
                    if (len > psagg_pkg::MAX_MAPS) begin
                        smp = $urandom;
                    end else begin
                        case ($urandom_range(9))
                            0:       smp = nodata_long;
                            1:       smp = nodata_short;
                            2:       smp = INT_MAX_BITS;
                            3:       smp = INT_MIN_BITS;
                            4, 5:    smp = $urandom;
                            6:       smp = 32'(int'($urandom_range(131071)) - 65536);
                            default: smp = 32'(int'($urandom_range(600)) - 300);
                        endcase
                    end
                    send_sample(smp, j == len - 1, 1'b0, '0);
                    sent++;
                end
            end
            phase++;
        end
        steady = 1'b0;

        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
rtl/psagg_pkg.sv
rtl/psagg_cell.sv
rtl/psagg_div.sv
rtl/pixel_stack_aggregate_top.sv
rtl/psagg_chk.sv
tb/sv/pixel_stack_aggregate_top_tb.sv
